FILE: design/assert_macros.svh
// Assertion macros shared by the handle list RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dchl_pkg.sv
// Shared types and codes for the deduplicating handle list.
// No dependencies; used by the controller and the top level.
`default_nettype none

package dchl_pkg;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes
    localparam cmd_t CMD_INSERT     = 3'd0;
    localparam cmd_t CMD_REMOVE_IDX = 3'd1;
    localparam cmd_t CMD_REMOVE_KEY = 3'd2;
    localparam cmd_t CMD_READ       = 3'd3;
    localparam cmd_t CMD_CLEAR      = 3'd4;

    // Status codes
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FULL = 2'd1;
    localparam status_t ST_DUP  = 2'd2;
    localparam status_t ST_MISS = 2'd3;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   entry_key;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

`default_nettype wire

FILE: design/dchl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dchl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/dchl_ctrl.sv
// Command sequencer for the handle list: fill count, search, compaction, read.
// Depends on dchl_pkg and drives one dchl_ram instance through its ports.
`default_nettype none
`include "assert_macros.svh"

module dchl_ctrl #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32,
    localparam int IDX_W   = $clog2(DEPTH),
    localparam int STORE_W = (KEY_BITS < 32) ? KEY_BITS : 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire dchl_pkg::cmd_t                   cmd,
    input  wire logic [dchl_pkg::KEY_W-1:0]       key,
    input  wire logic [dchl_pkg::POS_W-1:0]       position,
    input  wire logic                             slot_free,
    output logic                                  done,
    output dchl_pkg::result_t                     result,
    output logic                                  ram_we,
    output logic [IDX_W-1:0]                      ram_waddr,
    output logic [STORE_W-1:0]                    ram_wdata,
    output logic                                  ram_re,
    output logic [IDX_W-1:0]                      ram_raddr,
    input  wire logic [STORE_W-1:0]               ram_rdata
);

    import dchl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_RD_ADDR = 3'd3;
    localparam logic [2:0] S_RD_DATA = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [STORE_W-1:0] key_reg, key_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   didx_reg, didx_next;
    logic               rvld_reg, rvld_next;
    status_t            stat_reg, stat_next;
    logic [KEY_W-1:0]   rkey_reg, rkey_next;

    logic               issue;
    logic               hit;
    logic               pos_in_range;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   rd_idx;

    // Walk pointer still inside the filled entries
    assign issue = ptr_reg < count_reg;
    // Compare the entry read last cycle
    assign hit = rvld_reg && (ram_rdata == key_reg);
    assign pos_in_range = CMP_W'(position) < CMP_W'(count_reg);
    assign cnt_m1 = count_reg - CNT_W'(1);

    // Clamp a read index to the last filled entry
    always_comb
    begin
        if (CMP_W'(pos_reg) >= CMP_W'(count_reg))
        begin
            rd_idx = cnt_m1[IDX_W-1:0];
        end
        else
        begin
            rd_idx = IDX_W'(pos_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        didx_next  = didx_reg;
        rvld_next  = 1'b0;
        stat_next  = stat_reg;
        rkey_next  = rkey_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[IDX_W-1:0];
        ram_wdata  = key_reg;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[IDX_W-1:0];
        done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = cmd;
                    key_next  = key[STORE_W-1:0];
                    pos_next  = position;
                    ptr_next  = '0;
                    rkey_next = '0;
                    case (cmd)
                        CMD_INSERT, CMD_REMOVE_KEY:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_REMOVE_IDX:
                        begin
                            if (pos_in_range)
                            begin
                                ptr_next   = CNT_W'(position) + CNT_W'(1);
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                stat_next  = ST_MISS;
                                state_next = S_FINISH;
                            end
                        end
                        CMD_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_RD_ADDR;
                            end
                            else
                            begin
                                stat_next  = ST_MISS;
                                state_next = S_FINISH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            stat_next  = ST_OK;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            stat_next  = ST_MISS;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read of the search walk
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                    didx_next = ptr_reg[IDX_W-1:0];
                end
                if (hit)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        stat_next  = ST_DUP;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Close the gap starting at the match
                        ptr_next   = CNT_W'(didx_reg) + CNT_W'(1);
                        rvld_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else if (!issue)
                begin
                    state_next = S_FINISH;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            // Append at the end of the list
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = key_reg;
                            count_next = count_reg + CNT_W'(1);
                            stat_next  = ST_OK;
                        end
                    end
                    else
                    begin
                        stat_next = ST_MISS;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read entry i+1 while moving the previous one, entry i, down to i-1
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                    didx_next = ptr_reg[IDX_W-1:0];
                end
                if (rvld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = didx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (!issue)
                begin
                    count_next = cnt_m1;
                    stat_next  = ST_OK;
                    state_next = S_FINISH;
                end
            end

            S_RD_ADDR:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rd_idx;
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                rkey_next  = KEY_W'(ram_rdata);
                stat_next  = ST_OK;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Hand the result over once the output slot is free
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rvld_reg  <= rvld_next;
        end
    end

    // Command and walk payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        ptr_reg  <= ptr_next;
        didx_reg <= didx_next;
        stat_reg <= stat_next;
        rkey_reg <= rkey_next;
    end

    assign req_ready          = (state_reg == S_IDLE);
    assign result.status      = stat_reg;
    assign result.entry_key   = rkey_reg;
    assign result.entry_count = COUNT_W'(count_reg);

    `ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `ASSERT_IMPLY(a_rw_apart, ram_we && ram_re, ram_waddr != ram_raddr, "read and write collide")
    `ASSERT_NEXT(a_clear, req_valid && req_ready && cmd == CMD_CLEAR, count_reg == '0, "no clear")

endmodule

`default_nettype wire

FILE: design/dedup_compacting_handle_list_top.sv
// Insert and remove by key walk the entry memory, which has one read port and one write
// port with a registered read. Insert stops early when a duplicate is found. Both removes
// compact the entries above the removed one; remove by index goes straight to the result
// when the index is out of range. Read fetches one entry (none on an empty list); clear and
// unknown commands go straight to the result. The final state waits while the output
// register still holds a result that rsp_ready has not taken. One command is in work at a
// time; req_ready is high only between commands. No clearing pass runs after reset.
// Top level: output register around dchl_ctrl and the dchl_ram entry memory. Uses dchl_pkg.
`default_nettype none
`include "assert_macros.svh"

module dedup_compacting_handle_list_top #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire dchl_pkg::cmd_t                     cmd,
    input  wire logic [dchl_pkg::KEY_W-1:0]         key,
    input  wire logic [dchl_pkg::POS_W-1:0]         position,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output dchl_pkg::status_t                       status,
    output logic [dchl_pkg::KEY_W-1:0]              entry_key,
    output logic [dchl_pkg::COUNT_W-1:0]            entry_count
);

    import dchl_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int STORE_W = (KEY_BITS < 32) ? KEY_BITS : 32;

    logic               slot_free;
    logic               done;
    result_t            result;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [STORE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [STORE_W-1:0] ram_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    result_t            res_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    dchl_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .key       (key),
        .position  (position),
        .slot_free (slot_free),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dchl_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Load a new result or drop the one just taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the result payload for the output transaction
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= result;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = res_reg.status;
    assign entry_key   = res_reg.entry_key;
    assign entry_count = res_reg.entry_count;

    `ASSERT_IMPLY(a_no_overwrite, done, !rsp_valid_reg || rsp_ready, "result overwritten")
    `ASSERT_NEXT(a_result_loaded, done, rsp_valid_reg && res_reg == $past(result), "not loaded")
    `ASSERT_NEXT(a_rsp_hold, rsp_valid_reg && !rsp_ready, rsp_valid_reg && $stable(res_reg), "drop")

endmodule

`default_nettype wire

FILE: sim/dedup_compacting_handle_list_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for dedup_compacting_handle_list_top: directed and random commands.
// A shadow copy of the handle list predicts every response. Depends on dchl_pkg and the RTL.

module dedup_compacting_handle_list_top_test;
    import dchl_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RANDOM_CMDS = 650;
    localparam int QUIET_FROM  = 570;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;

    // Shadow of the handle list plus the queue of responses it predicts
    class handle_list_mirror;
        logic [KEY_W-1:0] slot [SLOTS];
        int unsigned      fill;
        result_t          pending_results [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      status_seen [4];

        function new();
            fill    = 0;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function int locate(logic [KEY_W-1:0] k);
            for (int i = 0; i < fill; i++)
                if (slot[i] == k)
                    return i;
            return -1;
        endfunction

        // Close the gap left by the entry at idx
        function void drop(int unsigned idx);
            fill--;
            for (int unsigned i = idx; i < fill; i++)
                slot[i] = slot[i + 1];
        endfunction

        // Apply one accepted transaction and queue its response
        function void note_command(cmd_t op, logic [KEY_W-1:0] k, logic [POS_W-1:0] pos);
            result_t r;
            int      hit;
            r.status    = ST_MISS;
            r.entry_key = '0;
            hit         = locate(k);
            case (op)
                CMD_INSERT:
                begin
                    if (hit >= 0)
                        r.status = ST_DUP;
                    else if (fill >= SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        slot[fill] = k;
                        fill++;
                        r.status = ST_OK;
                    end
                end
                CMD_REMOVE_IDX:
                begin
                    if (pos < fill)
                    begin
                        drop(pos);
                        r.status = ST_OK;
                    end
                end
                CMD_REMOVE_KEY:
                begin
                    if (hit >= 0)
                    begin
                        drop(hit);
                        r.status = ST_OK;
                    end
                end
                CMD_READ:
                begin
                    if (fill > 0)
                    begin
                        // clamp an index past the end to the last filled entry
                        r.entry_key = slot[(pos >= fill) ? fill - 1 : pos];
                        r.status    = ST_OK;
                    end
                end
                CMD_CLEAR:
                begin
                    fill     = 0;
                    r.status = ST_OK;
                end
                default:
                    ;
            endcase
            r.entry_count = COUNT_W'(fill);
            pending_results = {pending_results, r};
        endfunction

        // Compare one response against the oldest prediction
        function void check_result(status_t st, logic [KEY_W-1:0] ek, logic [COUNT_W-1:0] ec);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with nothing pending: status %0d key %h count %0d",
                         $time, st, ek, ec);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (ek !== want.entry_key)
            begin
                $display("%0t: entry_key expected %h actual %h", $time, want.entry_key, ek);
                errors++;
            end
            if (ec !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, ec);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   position;
    logic               rsp_valid;
    logic               rsp_ready;
    status_t            status;
    logic [KEY_W-1:0]   entry_key;
    logic [COUNT_W-1:0] entry_count;

    handle_list_mirror mirror = new();
    bit                quiet = 1'b0;
    int unsigned       idle_cycles = 0;
    int unsigned       stall_left = 0;
    int unsigned       op_seen [8] = '{default: 0};

    dedup_compacting_handle_list_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .key         (key),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .entry_key   (entry_key),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Observe both channels, predict and check, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                mirror.note_command(cmd, key, position);
                op_seen[cmd]++;
            end
            if (rsp_valid && rsp_ready)
                mirror.check_result(status, entry_key, entry_count);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stall the response channel in short random bursts
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            rsp_ready <= 1'b1;
    end

    // Offer one command, with an optional idle burst first, and hold it until accepted
    task send_command(input cmd_t op, input logic [KEY_W-1:0] k, input logic [POS_W-1:0] pos);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= op;
        key       <= k;
        position  <= pos;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    initial
    begin
        logic [KEY_W-1:0] pool [20];
        int               roll;
        bit               grow;
        cmd_t             op;
        logic [KEY_W-1:0] k;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        cmd       <= CMD_INSERT;
        key       <= '0;
        position  <= '0;
        foreach (pool[i])
            pool[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: read, both removes miss, unknown opcodes are ignored
        send_command(CMD_READ, 32'h0, 4'd0);
        send_command(CMD_REMOVE_IDX, 32'h0, 4'd0);
        send_command(CMD_REMOVE_KEY, 32'h1234_5678, 4'd0);
        send_command(cmd_t'(5), 32'hFFFF_FFFF, 4'd15);
        send_command(cmd_t'(6), 32'h0, 4'd0);
        send_command(cmd_t'(7), 32'hA5A5_5A5A, 4'd7);
        // Key extremes, a duplicate, a clamped read and an in-range read
        send_command(CMD_INSERT, 32'h0, 4'd0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_command(CMD_INSERT, 32'h0, 4'd0);
        send_command(CMD_READ, 32'h0, 4'd15);
        send_command(CMD_READ, 32'h0, 4'd0);
        // Fill to capacity, then hit full and a duplicate on a full list
        for (int i = 0; i < SLOTS - 2; i++)
            send_command(CMD_INSERT, 32'h1000_0000 + i, 4'd0);
        send_command(CMD_INSERT, 32'hDEAD_BEEF, 4'd0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_command(CMD_READ, 32'h0, 4'd15);
        // Remove last, first and a middle entry, then clear
        send_command(CMD_REMOVE_IDX, 32'h0, 4'd15);
        send_command(CMD_REMOVE_IDX, 32'h0, 4'd0);
        send_command(CMD_REMOVE_KEY, 32'h1000_0005, 4'd0);
        send_command(CMD_CLEAR, 32'h0, 4'd0);

        // Random phases alternately grow and shrink the list
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            quiet = (n >= QUIET_FROM);
            grow  = ((n / 60) % 2) == 0;
            roll  = $urandom_range(0, 99);
            if (grow)
                op = (roll < 55) ? CMD_INSERT : (roll < 65) ? CMD_REMOVE_IDX :
                     (roll < 75) ? CMD_REMOVE_KEY : (roll < 95) ? CMD_READ :
                     (roll < 97) ? CMD_CLEAR : cmd_t'($urandom_range(5, 7));
            else
                op = (roll < 30) ? CMD_INSERT : (roll < 50) ? CMD_REMOVE_IDX :
                     (roll < 70) ? CMD_REMOVE_KEY : (roll < 93) ? CMD_READ :
                     (roll < 96) ? CMD_CLEAR : cmd_t'($urandom_range(5, 7));
            // mostly reuse a small pool so duplicates and key hits happen
            k = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 19)];
            send_command(op, k, 4'($urandom_range(0, 15)));
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then give the block time to misbehave
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent: %0d ins, %0d rm idx, %0d rm key, %0d rd, %0d clr, %0d unknown",
                 op_seen[CMD_INSERT], op_seen[CMD_REMOVE_IDX], op_seen[CMD_REMOVE_KEY],
                 op_seen[CMD_READ], op_seen[CMD_CLEAR], op_seen[5] + op_seen[6] + op_seen[7]);
        $display("Responses checked: %0d (ok %0d, full %0d, duplicate %0d, miss %0d)",
                 mirror.checked, mirror.status_seen[ST_OK], mirror.status_seen[ST_FULL],
                 mirror.status_seen[ST_DUP], mirror.status_seen[ST_MISS]);
        if (mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: dedup_compacting_handle_list_top.f
+incdir+design
design/dchl_pkg.sv
design/dchl_ram.sv
design/dchl_ctrl.sv
design/dedup_compacting_handle_list_top.sv
sim/dedup_compacting_handle_list_top_test.sv
